[src/ppt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_pkg: shared types and constants of the pending packet table
// Request and result payloads, the queued command, the slot entry and the
// back-end state encoding.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int SLOTS_DEF = 16;

  // request operation codes
  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_FULL     = 2'd1;
  localparam logic [1:0] KIND_RELEASED = 2'd2;
  localparam logic [1:0] KIND_NOMATCH  = 2'd3;

  typedef struct packed {
    logic        op;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] pkt_handle;
  } ppt_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] released_handle;
    logic        last;
  } ppt_out_t;

  // classified request as it waits in the command queue
  typedef struct packed {
    logic        is_dispatch;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] handle;
  } ppt_cmd_t;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] handle;
  } ppt_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN
  } ppt_bk_state_t;

endpackage

[src/ppt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_front: request intake
// Decodes each request into a command and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module ppt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppt_pkg::ppt_in_t  in_pkt,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output ppt_pkg::ppt_cmd_t cmd
);
  import ppt_pkg::*;

  ppt_cmd_t   q_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  ppt_cmd_t   dec;
  logic       push;
  logic       pop;

  always_comb begin
    dec.is_dispatch = (in_pkt.op == OP_DISPATCH);
    dec.addr_hi     = in_pkt.addr_hi;
    dec.addr_lo     = in_pkt.addr_lo;
    dec.handle      = in_pkt.pkt_handle;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wptr_r] <= dec;
  end

endmodule

[src/ppt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_back: slot table and command execution
// Adds go to the lowest free slot; dispatches scan the slot memory one entry
// per cycle while no match waits on the result, and release every matching used slot.
// ----------------------------------------------------------------------------
module ppt_back #(
  parameter int SLOTS = ppt_pkg::SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  ppt_pkg::ppt_cmd_t cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output ppt_pkg::ppt_out_t out_pkt
);
  import ppt_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  ppt_entry_t    mem [SLOTS];
  ppt_entry_t    rd_data_r;
  logic          rd_vld_r;
  logic [IW-1:0] rd_slot_r;
  logic [CW-1:0] cnt_r;
  logic [SLOTS-1:0] used_r;
  logic [63:0]   tgt_hi_r;
  logic [63:0]   tgt_lo_r;
  logic          held_vld_r;
  logic [15:0]   held_handle_r;
  logic          out_valid_r;
  ppt_out_t      out_pkt_r;
  ppt_bk_state_t state_r, state_nxt;

  logic          out_free;
  logic          hit;
  logic          stall;
  logic          scan_done;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] rd_idx;

  logic          emit;
  ppt_out_t      emit_pkt;
  logic          mem_we;
  logic          rd_en;
  logic          start_scan;
  logic          take_hit;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign scan_done = (cnt_r == CW'(SLOTS));
  assign rd_idx    = cnt_r[IW-1:0];
  assign hit       = rd_vld_r && used_r[rd_slot_r] &&
                     (rd_data_r.addr_hi == tgt_hi_r) &&
                     (rd_data_r.addr_lo == tgt_lo_r);
  // a second match must wait until the held one can leave
  assign stall     = hit && held_vld_r && !out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && out_free && cmd.is_dispatch) state_nxt = BK_SCAN;
      end
      BK_SCAN: begin
        if (!stall && scan_done) state_nxt = BK_DRAIN;
      end
      BK_DRAIN: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready  = 1'b0;
    emit       = 1'b0;
    emit_pkt   = '0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    start_scan = 1'b0;
    take_hit   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        cmd_ready = out_free;
        if (cmd_valid && out_free) begin
          if (cmd.is_dispatch) begin
            start_scan = 1'b1;
          end else begin
            emit                 = 1'b1;
            emit_pkt.result_kind = free_found ? KIND_ACCEPTED : KIND_FULL;
            emit_pkt.last        = 1'b1;
            mem_we               = free_found;
          end
        end
      end
      BK_SCAN: begin
        if (!stall) begin
          take_hit                 = hit;
          emit                     = hit && held_vld_r;
          emit_pkt.result_kind     = KIND_RELEASED;
          emit_pkt.released_handle = held_handle_r;
          rd_en                    = !scan_done;
        end
      end
      BK_DRAIN: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_pkt.last = 1'b1;
          if (held_vld_r) begin
            emit_pkt.result_kind     = KIND_RELEASED;
            emit_pkt.released_handle = held_handle_r;
          end else begin
            emit_pkt.result_kind = KIND_NOMATCH;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      held_vld_r  <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (start_scan) begin
        cnt_r      <= '0;
        held_vld_r <= 1'b0;
        rd_vld_r   <= 1'b0;
      end
      if (state_r == BK_SCAN && !stall) rd_vld_r <= rd_en;
      if (rd_en) cnt_r <= cnt_r + CW'(1);
      if (mem_we) used_r[free_idx] <= 1'b1;
      if (take_hit) begin
        used_r[rd_slot_r] <= 1'b0;
        held_vld_r        <= 1'b1;
      end
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit)       out_pkt_r     <= emit_pkt;
    if (take_hit)   held_handle_r <= rd_data_r.handle;
    if (rd_en)      rd_slot_r     <= rd_idx;
    if (start_scan) begin
      tgt_hi_r <= cmd.addr_hi;
      tgt_lo_r <= cmd.addr_lo;
    end
  end

  // slot memory: one write port for adds, one registered read port for scans
  always_ff @(posedge clk) begin
    if (mem_we) mem[free_idx] <= '{addr_hi: cmd.addr_hi, addr_lo: cmd.addr_lo,
                                   handle: cmd.handle};
    if (rd_en)  rd_data_r     <= mem[rd_idx];
  end

  assign out_valid = out_valid_r;
  assign out_pkt   = out_pkt_r;

endmodule

[src/pending_packet_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_packet_table: table of packets waiting for a route
// Requests pass through a two-entry command queue into the execution side,
// which owns the slot memory and a one-entry result register.
// ----------------------------------------------------------------------------
// An add request passes the command queue, then the result register.
// A dispatch reads the slot memory once per slot through its single read
//   port, then gives the final result; released handles leave at up to one
//   per cycle while the receiver takes them. Adds go at one per cycle while
//   results are taken; no request enters the back end during a dispatch.
// Reset (rst_n low, synchronous): all slots free, queue and result empty.
// ----------------------------------------------------------------------------
module pending_packet_table #(
  parameter int SLOTS = ppt_pkg::SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ppt_pkg::ppt_in_t in_pkt,
  output logic             out_valid,
  input  logic             out_ready,
  output ppt_pkg::ppt_out_t out_pkt
);
  import ppt_pkg::*;

  // decoded request between intake and execution
  logic     cmd_valid;
  logic     cmd_ready;
  ppt_cmd_t cmd;

  // Front end: decodes the op and buffers up to two requests, so intake
  // keeps going while a dispatch scan or a stalled result holds the back.
  ppt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pkt    (in_pkt),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Back end: used flags in flops, addresses and handles in a slot memory.
  // A released handle is held back one match so that the final one can
  // carry the last flag.
  ppt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pkt   (out_pkt)
  );

endmodule

[src/ppt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_checker: port-level checks of the pending packet table
// Watches the result channel and reset behavior.
// ----------------------------------------------------------------------------
module ppt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input ppt_pkg::ppt_out_t out_pkt
);
  import ppt_pkg::*;

  // a result held back by the consumer stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pkt))
    else $error("result changed while stalled");

  // accepted, full and no-match are always the only result of a request
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pkt.result_kind != KIND_RELEASED |-> out_pkt.last)
    else $error("non-release result without last");

  a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pkt.result_kind != KIND_RELEASED |->
      out_pkt.released_handle == 16'd0)
    else $error("handle set on non-release result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pending_packet_table ppt_checker u_ppt_checker (.*);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the pending packet table
// Drives add and dispatch requests with random idle gaps on both channels,
// keeps a shadow copy of the slot table to predict every result in order,
// and compares each result field by field as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;
  import ppt_pkg::*;

  localparam int SLOTS        = SLOTS_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int POOL_SIZE    = 6;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ppt_in_t  in_pkt;
  logic     out_valid;
  logic     out_ready;
  ppt_out_t out_pkt;

  // shadow copy of the slot table, updated at request acceptance
  logic        slot_used   [SLOTS];
  logic [63:0] slot_hi     [SLOTS];
  logic [63:0] slot_lo     [SLOTS];
  logic [15:0] slot_handle [SLOTS];

  // results still owed by the block, oldest first
  ppt_out_t table_outcomes[$];
  ppt_out_t owed;

  // destination pool for well-formed traffic
  logic [63:0] pool_hi[POOL_SIZE];
  logic [63:0] pool_lo[POOL_SIZE];

  int  fail_count  = 0;
  int  cycle_count = 0;
  bit  src_idle    = 1'b1;  // sender inserts random gaps
  bit  sink_idle   = 1'b1;  // receiver inserts random stalls
  int  sink_hold   = 0;     // one-shot long stall request for the receiver

  pending_packet_table #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pkt   (in_pkt),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pkt  (out_pkt)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results owed", cycle_count,
               table_outcomes.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h, wanted %0h (cycle %0d)", what, got, want,
             cycle_count);
    fail_count++;
  endtask

  // Apply one accepted request to the shadow table and queue its results.
  // Adds take the lowest free slot; dispatch frees every used slot whose
  // full 128-bit address matches, lowest slot first. Free slots never match.
  function automatic void table_apply(input ppt_in_t req);
    int       free_slot;
    int       released;
    ppt_out_t res;
    free_slot = -1;
    released  = 0;
    if (req.op == OP_ADD) begin
      for (int i = SLOTS - 1; i >= 0; i--)
        if (!slot_used[i]) free_slot = i;
      res.released_handle = '0;
      res.last            = 1'b1;
      if (free_slot < 0) begin
        res.result_kind = KIND_FULL;
      end else begin
        slot_used[free_slot]   = 1'b1;
        slot_hi[free_slot]     = req.addr_hi;
        slot_lo[free_slot]     = req.addr_lo;
        slot_handle[free_slot] = req.pkt_handle;
        res.result_kind        = KIND_ACCEPTED;
      end
      table_outcomes.push_back(res);
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && slot_hi[i] == req.addr_hi && slot_lo[i] == req.addr_lo) begin
          slot_used[i]        = 1'b0;
          res.result_kind     = KIND_RELEASED;
          res.released_handle = slot_handle[i];
          res.last            = 1'b0;
          table_outcomes.push_back(res);
          released++;
        end
      end
      if (released == 0) begin
        res.result_kind     = KIND_NOMATCH;
        res.released_handle = '0;
        res.last            = 1'b1;
        table_outcomes.push_back(res);
      end else begin
        // only the final release of the request carries last
        res      = table_outcomes.pop_back();
        res.last = 1'b1;
        table_outcomes.push_back(res);
      end
    end
  endfunction

  // Offer one request and hold it until accepted. Called and returning at a
  // rising edge; valid stays high on return so back-to-back requests never
  // drop it. Inputs are stable from posedge to posedge, so ready sampled at
  // the falling edge is the value the next rising edge will see.
  task automatic send_request(input logic op, input logic [63:0] hi,
                              input logic [63:0] lo, input logic [15:0] handle);
    int      gap;
    ppt_in_t req;
    req.op         = op;
    req.addr_hi    = hi;
    req.addr_lo    = lo;
    req.pkt_handle = handle;
    gap = src_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pkt   <= req;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    table_apply(req);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Receiver: per result a random stall, or a long hold when requested.
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      stall = sink_idle ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid && sink_hold == 0);
      @(posedge clk);
    end
  end

  // Result checker: a result seen at the falling edge with ready high is
  // taken at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (table_outcomes.size() == 0) begin
        report_mismatch("result with nothing owed", 32'(out_pkt), '0);
      end else begin
        owed = table_outcomes.pop_front();
        if (out_pkt.result_kind !== owed.result_kind)
          report_mismatch("result_kind", 32'(out_pkt.result_kind),
                          32'(owed.result_kind));
        if (out_pkt.released_handle !== owed.released_handle)
          report_mismatch("released_handle", 32'(out_pkt.released_handle),
                          32'(owed.released_handle));
        if (out_pkt.last !== owed.last)
          report_mismatch("last", 32'(out_pkt.last), 32'(owed.last));
      end
    end
  end

  // Field extremes, half-address mismatch, and a freed slot that still
  // holds the target address.
  task automatic test_basics();
    send_request(OP_ADD, '1, '1, 16'hFFFF);
    send_request(OP_ADD, '0, '0, 16'h0000);
    send_request(OP_DISPATCH, '1, '0, 16'($urandom));
    send_request(OP_DISPATCH, '1, '1, 16'($urandom));
    send_request(OP_DISPATCH, '1, '1, 16'($urandom));
    send_request(OP_DISPATCH, '0, '0, 16'($urandom));
  endtask

  // Fill every slot with one address, overflow, miss on a full table, then
  // release all slots in one dispatch.
  task automatic test_full_table();
    logic [63:0] x_hi;
    logic [63:0] x_lo;
    x_hi = 64'h5555_5555_5555_5555;
    x_lo = 64'hAAAA_AAAA_AAAA_AAAA;
    for (int i = 0; i < SLOTS; i++)
      send_request(OP_ADD, x_hi, x_lo, 16'($urandom));
    send_request(OP_ADD, x_lo, x_hi, 16'($urandom));
    send_request(OP_DISPATCH, x_lo, x_hi, 16'($urandom));
    send_request(OP_DISPATCH, x_hi, x_lo, 16'($urandom));
  endtask

  // Receiver stalls for a long stretch while requests keep coming, so the
  // command queue and result register fill and in_ready drops.
  task automatic test_backpressure();
    int k;
    src_idle  = 1'b0;
    sink_hold = 150;
    for (int n = 0; n < 30; n++) begin
      k = $urandom_range(0, POOL_SIZE - 1);
      send_request(($urandom_range(0, 99) < 70) ? OP_ADD : OP_DISPATCH,
                   pool_hi[k], pool_lo[k], 16'($urandom));
    end
    src_idle = 1'b1;
  endtask

  // Mostly add/dispatch traffic on a small address pool so slots fill, match
  // and get reused; some requests carry fully random addresses as noise.
  task automatic test_random_traffic();
    int          add_bias;
    int          k;
    logic        op;
    logic [63:0] hi;
    logic [63:0] lo;
    add_bias = 50;
    for (int n = 0; n < 250; n++) begin
      if (n % 40 == 0) begin
        add_bias  = $urandom_range(30, 85);
        src_idle  = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
      end
      op = ($urandom_range(0, 99) < add_bias) ? OP_ADD : OP_DISPATCH;
      if ($urandom_range(0, 99) < 10) begin
        hi = rand64();
        lo = rand64();
      end else begin
        k  = $urandom_range(0, POOL_SIZE - 1);
        hi = pool_hi[k];
        lo = pool_lo[k];
      end
      send_request(op, hi, lo, 16'($urandom));
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  initial begin : run
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_pkt   <= '0;
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    // pool: all ones, all zero, a pair sharing the upper half, a pair sharing the lower half
    pool_hi[0] = '1;
    pool_lo[0] = '1;
    pool_hi[1] = '0;
    pool_lo[1] = '0;
    pool_hi[2] = rand64();
    pool_lo[2] = rand64();
    pool_hi[3] = pool_hi[2];
    pool_lo[3] = rand64();
    pool_hi[4] = rand64();
    pool_lo[4] = rand64();
    pool_hi[5] = rand64();
    pool_lo[5] = pool_lo[4];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_basics();
    test_full_table();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;

    while (table_outcomes.size() != 0) @(posedge clk);
    // a stray result after the last owed one would show up here
    repeat (SLOTS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
